### sv/ptbs_pkg.sv
`default_nettype none
package ptbs_pkg;

  localparam int MAX_VERTICAL_DEF   = 128;
  localparam int MAX_HORIZONTAL_DEF = 64;

  localparam int FULL_TURN    = 23040;
  localparam int HALF_TURN    = 11520;
  localparam int QUARTER_TURN = 5760;

  localparam int DIV_STEPS = 16;
  localparam logic [16:0] W_ONE = 17'h10000;
  localparam logic [58:0] ROUND_HALF = 59'h0_8000_0000;

  localparam logic [1:0] OP_LOAD_V  = 2'd0;
  localparam logic [1:0] OP_LOAD_H  = 2'd1;
  localparam logic [1:0] OP_LOAD_CD = 2'd2;
  localparam logic [1:0] OP_SAMPLE  = 2'd3;

  localparam logic CFG_VCOUNT = 1'b0;
  localparam logic CFG_HCOUNT = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_VSRCH,
    ST_VDIV,
    ST_HSRCH,
    ST_HDIV,
    ST_CBASE,
    ST_CRD,
    ST_MAC
  } ptbs_state_t;

  typedef struct packed {
    logic        vld;
    logic [15:0] rem;
    logic [14:0] den;
    logic [15:0] quo;
  } ptbs_div_t;

endpackage
`default_nettype wire

### sv/photometric_table_bilinear_sampler.sv
`default_nettype none
// Photometric table sampler. Loads (opcodes 0..2) are taken while idle and busy stays low.
// A sample keeps busy high through a linear scan of each angle table at one memory read
// per cycle that stops at the bracketing entry (no horizontal scan for an axial table),
// a 16-cell pipelined divider for each weight that is not 0 or 1, four candela reads
// and six passes through one shared multiplier. The result is shown for one cycle with
// out_valid high, in the cycle busy drops; there is no stall, so the receiver must take
// every beat.
module photometric_table_bilinear_sampler #(
  parameter int MAX_VERTICAL   = ptbs_pkg::MAX_VERTICAL_DEF,
  parameter int MAX_HORIZONTAL = ptbs_pkg::MAX_HORIZONTAL_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [1:0]         in_opcode,
  input  wire logic [12:0]        in_entry_index,
  input  wire logic [14:0]        in_load_angle,
  input  wire logic [23:0]        in_load_candela,
  input  wire logic [13:0]        in_query_vertical,
  input  wire logic signed [15:0] in_query_horizontal,
  output logic                    out_valid,
  output logic [23:0]             out_candela_out,
  input  wire logic               cfg_we,
  input  wire logic               cfg_index,
  input  wire logic [7:0]         cfg_data
);

  localparam int VAW = (MAX_VERTICAL > 1) ? $clog2(MAX_VERTICAL) : 1;
  localparam int HAW = (MAX_HORIZONTAL > 1) ? $clog2(MAX_HORIZONTAL) : 1;
  localparam int SW  = ((VAW > HAW) ? VAW : HAW) + 1;
  localparam int CD_DEPTH = MAX_VERTICAL * MAX_HORIZONTAL;
  localparam int CAW = (CD_DEPTH > 1) ? $clog2(CD_DEPTH) : 1;

  ptbs_pkg::ptbs_state_t state_r, state_nxt;

  logic [7:0]  vcount_r;
  logic [6:0]  hcount_r;
  logic [14:0] last_r;
  logic [SW-1:0] nv, nh, n_sel;

  logic [13:0] vmem [MAX_VERTICAL];
  logic [14:0] hmem [MAX_HORIZONTAL];
  logic [23:0] cmem [CD_DEPTH];
  logic [13:0] vq_r;
  logic [14:0] hq_r;
  logic [23:0] cq_r;
  logic [CAW-1:0] caddr;

  logic accept, ld_v, ld_h, ld_c, smp;

  logic [13:0] qv_r, qv_nxt;
  logic [14:0] qh_r, qh_nxt;
  logic signed [17:0] hs0, hs1, hs2;
  logic [14:0] hu, hf;

  logic [SW-1:0] k_r, k_nxt, dk_r, dk_nxt;
  logic dv_r, dv_nxt;
  logic [14:0] prev_r, prev_nxt, td, q_sel;
  logic found, w_zero, w_full, special, in_srch;

  ptbs_pkg::ptbs_div_t din, dout;

  logic [VAW-1:0] v0_r, v0_nxt;
  logic [HAW-1:0] h0_r, h0_nxt;
  logic [16:0] wv_r, wv_nxt, wh_r, wh_nxt;
  logic [CAW-1:0] base_r, base_nxt;
  logic [2:0] c_r, c_nxt, m_r, m_nxt;
  logic [23:0] cd0_r, cd1_r, cd2_r, cd3_r, cd0_nxt, cd1_nxt, cd2_nxt, cd3_nxt;
  logic [40:0] t0_r, t0_nxt, t1_r, t1_nxt, a_sel;
  logic [16:0] b_sel;
  logic [57:0] prod, acc_r, acc_nxt;
  logic [58:0] rnd;
  logic out_valid_r, out_valid_nxt;
  logic [23:0] out_cd_r, out_cd_nxt;

  always_comb begin
    if (vcount_r < 8'd2) begin
      nv = SW'(2);
    end else if (32'(vcount_r) > MAX_VERTICAL) begin
      nv = SW'(MAX_VERTICAL);
    end else begin
      nv = SW'(vcount_r);
    end
    if (hcount_r == 7'd0) begin
      nh = SW'(1);
    end else if (32'(hcount_r) > MAX_HORIZONTAL) begin
      nh = SW'(MAX_HORIZONTAL);
    end else begin
      nh = SW'(hcount_r);
    end
  end

  assign busy   = (state_r != ptbs_pkg::ST_IDLE);
  assign accept = start & ~busy;
  assign ld_v = accept && in_opcode == ptbs_pkg::OP_LOAD_V
                && 32'(in_entry_index) < MAX_VERTICAL;
  assign ld_h = accept && in_opcode == ptbs_pkg::OP_LOAD_H
                && 32'(in_entry_index) < MAX_HORIZONTAL;
  assign ld_c = accept && in_opcode == ptbs_pkg::OP_LOAD_CD
                && 32'(in_entry_index) < CD_DEPTH;
  assign smp  = accept && in_opcode == ptbs_pkg::OP_SAMPLE;

  // horizontal wrap and symmetry fold
  always_comb begin
    hs0 = 18'(in_query_horizontal);
    if (hs0 >= ptbs_pkg::FULL_TURN) begin
      hs1 = hs0 - 18'(ptbs_pkg::FULL_TURN);
    end else if (hs0 < 0) begin
      hs1 = hs0 + 18'(ptbs_pkg::FULL_TURN);
    end else begin
      hs1 = hs0;
    end
    hs2 = (hs1 < 0) ? hs1 + 18'(ptbs_pkg::FULL_TURN) : hs1;
    hu  = 15'(hs2);
    if (last_r == 15'd0) begin
      hf = 15'd0;
    end else if (last_r <= 15'(ptbs_pkg::QUARTER_TURN)) begin
      if (hu >= 15'(3 * ptbs_pkg::QUARTER_TURN)) begin
        hf = hu - 15'(3 * ptbs_pkg::QUARTER_TURN);
      end else if (hu >= 15'(2 * ptbs_pkg::QUARTER_TURN)) begin
        hf = hu - 15'(2 * ptbs_pkg::QUARTER_TURN);
      end else if (hu >= 15'(ptbs_pkg::QUARTER_TURN)) begin
        hf = hu - 15'(ptbs_pkg::QUARTER_TURN);
      end else begin
        hf = hu;
      end
    end else if (last_r <= 15'(ptbs_pkg::HALF_TURN) && hu > 15'(ptbs_pkg::HALF_TURN)) begin
      hf = 15'(ptbs_pkg::FULL_TURN) - hu;
    end else begin
      hf = hu;
    end
    qh_nxt = (hf > last_r) ? last_r : hf;
    qv_nxt = in_query_vertical;
  end

  // memories
  always_ff @(posedge clk) begin
    if (ld_v) begin
      vmem[VAW'(in_entry_index)] <= in_load_angle[13:0];
    end
    if (ld_h) begin
      hmem[HAW'(in_entry_index)] <= in_load_angle;
    end
    if (ld_c) begin
      cmem[CAW'(in_entry_index)] <= in_load_candela;
    end
    vq_r <= vmem[VAW'(k_r)];
    hq_r <= hmem[HAW'(k_r)];
    cq_r <= cmem[caddr];
  end

  // bracket search and weight
  assign in_srch = (state_r == ptbs_pkg::ST_VSRCH) || (state_r == ptbs_pkg::ST_HSRCH);
  assign td    = (state_r == ptbs_pkg::ST_VSRCH) ? {1'b0, vq_r} : hq_r;
  assign q_sel = (state_r == ptbs_pkg::ST_VSRCH) ? {1'b0, qv_r} : qh_r;
  assign n_sel = (state_r == ptbs_pkg::ST_VSRCH) ? nv : nh;
  assign found = in_srch && dv_r && dk_r != '0
                 && (td >= q_sel || dk_r == n_sel - SW'(1));
  assign w_zero  = (td <= prev_r) || (q_sel <= prev_r);
  assign w_full  = !w_zero && (q_sel >= td);
  assign special = w_zero | w_full;

  always_comb begin
    din.vld = found & ~special;
    din.rem = {1'b0, q_sel - prev_r};
    din.den = td - prev_r;
    din.quo = '0;
  end

  ptbs_divider u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .din  (din),
    .dout (dout)
  );

  // candela read address
  always_comb begin
    caddr = base_r + CAW'(v0_r) + CAW'(c_r[0]);
    if (c_r[1] && nh > SW'(1)) begin
      caddr = caddr + CAW'(nv);
    end
  end

  // shared multiplier
  always_comb begin
    case (m_r)
      3'd0: begin
        a_sel = 41'(cd0_r);
        b_sel = ptbs_pkg::W_ONE - wv_r;
      end
      3'd1: begin
        a_sel = 41'(cd1_r);
        b_sel = wv_r;
      end
      3'd2: begin
        a_sel = 41'(cd2_r);
        b_sel = ptbs_pkg::W_ONE - wv_r;
      end
      3'd3: begin
        a_sel = 41'(cd3_r);
        b_sel = wv_r;
      end
      3'd4: begin
        a_sel = t0_r;
        b_sel = ptbs_pkg::W_ONE - wh_r;
      end
      default: begin
        a_sel = t1_r;
        b_sel = wh_r;
      end
    endcase
  end

  assign prod = a_sel * b_sel;
  assign rnd  = {1'b0, acc_r} + {1'b0, prod} + ptbs_pkg::ROUND_HALF;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ptbs_pkg::ST_IDLE: begin
        if (smp) state_nxt = ptbs_pkg::ST_VSRCH;
      end
      ptbs_pkg::ST_VSRCH: begin
        if (found) begin
          if (!special) state_nxt = ptbs_pkg::ST_VDIV;
          else if (nh > SW'(1)) state_nxt = ptbs_pkg::ST_HSRCH;
          else state_nxt = ptbs_pkg::ST_CBASE;
        end
      end
      ptbs_pkg::ST_VDIV: begin
        if (dout.vld) begin
          state_nxt = (nh > SW'(1)) ? ptbs_pkg::ST_HSRCH : ptbs_pkg::ST_CBASE;
        end
      end
      ptbs_pkg::ST_HSRCH: begin
        if (found) state_nxt = special ? ptbs_pkg::ST_CBASE : ptbs_pkg::ST_HDIV;
      end
      ptbs_pkg::ST_HDIV: begin
        if (dout.vld) state_nxt = ptbs_pkg::ST_CBASE;
      end
      ptbs_pkg::ST_CBASE: state_nxt = ptbs_pkg::ST_CRD;
      ptbs_pkg::ST_CRD: begin
        if (c_r == 3'd4) state_nxt = ptbs_pkg::ST_MAC;
      end
      ptbs_pkg::ST_MAC: begin
        if (m_r == 3'd5) state_nxt = ptbs_pkg::ST_IDLE;
      end
      default: state_nxt = ptbs_pkg::ST_IDLE;
    endcase
  end

  // datapath
  always_comb begin
    k_nxt = k_r;
    dv_nxt = dv_r;
    dk_nxt = dk_r;
    prev_nxt = prev_r;
    v0_nxt = v0_r;
    h0_nxt = h0_r;
    wv_nxt = wv_r;
    wh_nxt = wh_r;
    base_nxt = base_r;
    c_nxt = c_r;
    m_nxt = m_r;
    cd0_nxt = cd0_r;
    cd1_nxt = cd1_r;
    cd2_nxt = cd2_r;
    cd3_nxt = cd3_r;
    t0_nxt = t0_r;
    t1_nxt = t1_r;
    acc_nxt = acc_r;
    out_valid_nxt = 1'b0;
    out_cd_nxt = out_cd_r;

    if (in_srch) begin
      k_nxt  = (k_r < n_sel) ? k_r + SW'(1) : k_r;
      dv_nxt = (k_r < n_sel);
      dk_nxt = k_r;
      if (dv_r) prev_nxt = td;
      if (found) begin
        k_nxt  = '0;
        dv_nxt = 1'b0;
      end
    end else begin
      k_nxt  = '0;
      dv_nxt = 1'b0;
    end

    case (state_r)
      ptbs_pkg::ST_IDLE: begin
        h0_nxt = '0;
        wh_nxt = '0;
      end
      ptbs_pkg::ST_VSRCH: begin
        if (found) begin
          v0_nxt = VAW'(dk_r - SW'(1));
          wv_nxt = w_full ? ptbs_pkg::W_ONE : 17'd0;
        end
      end
      ptbs_pkg::ST_VDIV: begin
        if (dout.vld) wv_nxt = {1'b0, dout.quo};
      end
      ptbs_pkg::ST_HSRCH: begin
        if (found) begin
          h0_nxt = HAW'(dk_r - SW'(1));
          wh_nxt = w_full ? ptbs_pkg::W_ONE : 17'd0;
        end
      end
      ptbs_pkg::ST_HDIV: begin
        if (dout.vld) wh_nxt = {1'b0, dout.quo};
      end
      ptbs_pkg::ST_CBASE: begin
        base_nxt = CAW'(h0_r) * CAW'(nv);
        c_nxt = '0;
        m_nxt = '0;
      end
      ptbs_pkg::ST_CRD: begin
        c_nxt = c_r + 3'd1;
        case (c_r)
          3'd1: cd0_nxt = cq_r;
          3'd2: cd1_nxt = cq_r;
          3'd3: cd2_nxt = cq_r;
          3'd4: cd3_nxt = cq_r;
          default: ;
        endcase
      end
      ptbs_pkg::ST_MAC: begin
        m_nxt = m_r + 3'd1;
        case (m_r)
          3'd0: t0_nxt = prod[40:0];
          3'd1: t0_nxt = t0_r + prod[40:0];
          3'd2: t1_nxt = prod[40:0];
          3'd3: t1_nxt = t1_r + prod[40:0];
          3'd4: acc_nxt = prod;
          default: begin
            out_valid_nxt = 1'b1;
            out_cd_nxt = rnd[55:32];
          end
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ptbs_pkg::ST_IDLE;
      vcount_r    <= 8'd2;
      hcount_r    <= 7'd1;
      last_r      <= '0;
      k_r         <= '0;
      dv_r        <= 1'b0;
      c_r         <= '0;
      m_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      k_r         <= k_nxt;
      dv_r        <= dv_nxt;
      c_r         <= c_nxt;
      m_r         <= m_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        if (cfg_index == ptbs_pkg::CFG_VCOUNT) vcount_r <= cfg_data;
        if (cfg_index == ptbs_pkg::CFG_HCOUNT) hcount_r <= cfg_data[6:0];
      end
      if (ld_h && 32'(in_entry_index) == 32'(nh) - 1) last_r <= in_load_angle;
    end
  end

  always_ff @(posedge clk) begin
    if (smp) begin
      qv_r <= qv_nxt;
      qh_r <= qh_nxt;
    end
    dk_r     <= dk_nxt;
    prev_r   <= prev_nxt;
    v0_r     <= v0_nxt;
    h0_r     <= h0_nxt;
    wv_r     <= wv_nxt;
    wh_r     <= wh_nxt;
    base_r   <= base_nxt;
    cd0_r    <= cd0_nxt;
    cd1_r    <= cd1_nxt;
    cd2_r    <= cd2_nxt;
    cd3_r    <= cd3_nxt;
    t0_r     <= t0_nxt;
    t1_r     <= t1_nxt;
    acc_r    <= acc_nxt;
    out_cd_r <= out_cd_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_candela_out = out_cd_r;

endmodule
`default_nettype wire

### sv/ptbs_div_cell.sv
`default_nettype none
module ptbs_div_cell (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire ptbs_pkg::ptbs_div_t din,
  output ptbs_pkg::ptbs_div_t      dout
);

  logic [16:0] shl;
  logic [16:0] diff;
  logic        ge;
  logic        vld_r;
  logic [15:0] rem_r, rem_nxt;
  logic [14:0] den_r;
  logic [15:0] quo_r, quo_nxt;

  assign shl  = {din.rem, 1'b0};
  assign ge   = shl >= {2'b00, din.den};
  assign diff = shl - {2'b00, din.den};

  always_comb begin
    rem_nxt = ge ? diff[15:0] : shl[15:0];
    quo_nxt = {din.quo[14:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= din.vld;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    den_r <= din.den;
    quo_r <= quo_nxt;
  end

  always_comb begin
    dout.vld = vld_r;
    dout.rem = rem_r;
    dout.den = den_r;
    dout.quo = quo_r;
  end

endmodule
`default_nettype wire

### sv/ptbs_divider.sv
`default_nettype none
module ptbs_divider (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire ptbs_pkg::ptbs_div_t din,
  output ptbs_pkg::ptbs_div_t      dout
);

  ptbs_pkg::ptbs_div_t stage [ptbs_pkg::DIV_STEPS + 1];

  assign stage[0] = din;

  for (genvar i = 0; i < ptbs_pkg::DIV_STEPS; i++) begin : g_cell
    ptbs_div_cell u_cell (
      .clk  (clk),
      .rst_n(rst_n),
      .din  (stage[i]),
      .dout (stage[i+1])
    );
  end

  assign dout = stage[ptbs_pkg::DIV_STEPS];

endmodule
`default_nettype wire
